>>> design/data_block_bitmap_allocator_top_defines.svh
// ---------------------------------------------------------------------------
// data_block_bitmap_allocator_top_defines
// assertion macros used by the bitmap allocator checker
// ---------------------------------------------------------------------------
`ifndef DATA_BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define DATA_BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DBBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbba check failed");

// next-cycle implication, disabled in reset
`define DBBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbba check failed");

`endif

>>> design/dbba_pkg.sv
// ---------------------------------------------------------------------------
// dbba_pkg
// types, codes and defaults of the data block bitmap allocator
// ---------------------------------------------------------------------------
package dbba_pkg;

  localparam int unsigned MAP_BITS_DEF  = 4096;
  localparam int unsigned WORD_BITS_DEF = 64;

  localparam logic [31:0] DATA_START_RST  = 32'd4;
  localparam logic [31:0] BLOCK_TOTAL_RST = 32'd0;
  localparam logic [12:0] FREE_MAX        = 13'h1fff;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_DATA_START  = 1'b0,
    CFG_BLOCK_TOTAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] block_number;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] granted_block;
    logic [12:0] free_count;
  } resp_t;

  // address width of a memory of the given depth, at least one bit
  function automatic int unsigned addr_w(int unsigned depth);
    int unsigned w;
    w = 1;
    while ((1 << w) < depth) begin
      w = w + 1;
    end
    return w;
  endfunction

endpackage

>>> design/dbba_ram.sv
// ---------------------------------------------------------------------------
// dbba_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module dbba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [dbba_pkg::addr_w(DEPTH)-1:0]     waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [dbba_pkg::addr_w(DEPTH)-1:0]     raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/data_block_bitmap_allocator_top.sv
// ---------------------------------------------------------------------------
// data_block_bitmap_allocator_top
// first-fit block allocator over a usage bitmap held in one ram
// ---------------------------------------------------------------------------
// usage:
//  - request channel (in_valid_i/in_ready_o/in_data_i): one beat is an
//    allocate or a free of block_number; exactly one response beat follows
//  - response channel (out_valid_o/out_ready_i/out_data_o): status, granted
//    block and the free count after the request
//  - config port: cfg_we_i writes data_start (index 0) or block_total
//    (index 1); write only while no request is in flight
//  - scan: words are streamed from the ram one per cycle from word 0;
//    the registered read word is evaluated while the next is in flight,
//    and the scan stops at the word holding the answer or once the
//    managed range is used up; an out-of-range free skips the scan
//  - one request at a time, set by the single ram read port; in_ready_o
//    returns once the response is loaded and the state is back in idle
//  - reset: the ram is cleared word by word, all MAP_WORDS words, with
//    in_ready_o low; config writes still land
//  - stall: a finished response waits in the output register; a new
//    request is still taken, its response then waits until the old beat
//    has been taken
// ---------------------------------------------------------------------------
module data_block_bitmap_allocator_top #(
  parameter int unsigned MAP_BITS  = dbba_pkg::MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = dbba_pkg::WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dbba_pkg::req_t      in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dbba_pkg::resp_t     out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = dbba_pkg::addr_w(MAP_WORDS);
  // bit offset inside a word
  localparam int unsigned OW        = dbba_pkg::addr_w(WORD_BITS);
  // bit index / word base, up to MAP_BITS + WORD_BITS - 1
  localparam int unsigned BW        = dbba_pkg::addr_w(MAP_BITS + WORD_BITS);
  // count of blocks in use, up to MAP_BITS
  localparam int unsigned CW        = dbba_pkg::addr_w(MAP_BITS + 1);

  // state and config
  dbba_pkg::state_e    state_q, state_d;
  logic [31:0]         ds_q, bt_q;
  logic [CW-1:0]       in_use_q, in_use_d;

  // request context
  dbba_pkg::func_e     func_q, func_d;
  logic [BW-1:0]       limit_q, limit_d;

  // read stream: issue side and evaluate side
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [BW-1:0]       rd_base_q, rd_base_d;
  logic                ev_vld_q, ev_vld_d;
  logic [AW-1:0]       ev_ptr_q, ev_ptr_d;
  logic [BW-1:0]       ev_base_q, ev_base_d;

  // pending result and output register
  dbba_pkg::status_e   res_status_q, res_status_d;
  logic [31:0]         res_grant_q, res_grant_d;
  logic                out_valid_q, out_valid_d;
  dbba_pkg::resp_t     out_data_q, out_data_d;

  // ram port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  // evaluation of the word on the read port
  logic                issue;
  logic [BW-1:0]       diff;
  logic [WORD_BITS-1:0] cand;
  logic                alloc_hit;
  logic [OW-1:0]       alloc_off;
  logic                free_word;
  logic [OW-1:0]       free_off;
  logic                free_set;
  logic [WORD_BITS-1:0] sel_mask;

  // request decode at accept
  logic                accept;
  logic [31:0]         span;
  logic [BW-1:0]       managed;
  logic [31:0]         free_idx;
  logic                free_bad;

  // free count
  logic [BW-1:0]       free_raw;
  logic [12:0]         free_cnt;

  dbba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // managed block count, capped at the bitmap size
  always_comb begin
    span = bt_q - ds_q;
    if (bt_q <= ds_q) begin
      managed = '0;
    end else if (span > 32'(MAP_BITS)) begin
      managed = BW'(MAP_BITS);
    end else begin
      managed = BW'(span);
    end
  end

  // free count after the request, saturated at both ends
  always_comb begin
    free_raw = (managed > BW'(in_use_q)) ? (managed - BW'(in_use_q)) : '0;
    free_cnt = (32'(free_raw) > 32'(dbba_pkg::FREE_MAX)) ? dbba_pkg::FREE_MAX
                                                         : 13'(free_raw);
  end

  // free range check, done at accept
  always_comb begin
    free_idx = in_data_i.block_number - ds_q;
    free_bad = (in_data_i.block_number < ds_q) || (in_data_i.block_number >= bt_q) ||
               (free_idx >= 32'(MAP_BITS));
  end

  assign accept = in_valid_i && in_ready_o;
  assign issue  = rd_base_q < limit_q;

  // bits of the current word that lie below the limit start at ev_base_q
  assign diff = limit_q - ev_base_q;

  // lowest clear bit inside the managed range
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      cand[k] = !ram_rdata[k] && (diff > BW'(k));
    end
    alloc_hit = 1'b0;
    alloc_off = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        alloc_hit = 1'b1;
        alloc_off = OW'(k);
      end
    end
  end

  // for a free the limit is index + 1, so the word holds it once diff fits
  assign free_word = diff <= BW'(WORD_BITS);
  assign free_off  = OW'(diff - BW'(1));
  assign free_set  = ram_rdata[free_off];

  assign sel_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1}
                    << ((func_q == dbba_pkg::FUNC_ALLOC) ? alloc_off : free_off);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dbba_pkg::S_CLEAR: begin
        if (rd_ptr_q == AW'(MAP_WORDS - 1)) begin
          state_d = dbba_pkg::S_IDLE;
        end
      end
      dbba_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data_i.func == dbba_pkg::FUNC_FREE && free_bad) begin
            state_d = dbba_pkg::S_RESP;
          end else begin
            state_d = dbba_pkg::S_SCAN;
          end
        end
      end
      dbba_pkg::S_SCAN: begin
        if (ev_vld_q) begin
          if ((func_q == dbba_pkg::FUNC_ALLOC && alloc_hit) ||
              (func_q == dbba_pkg::FUNC_FREE && free_word)) begin
            state_d = dbba_pkg::S_RESP;
          end
        end else if (!issue) begin
          state_d = dbba_pkg::S_RESP;
        end
      end
      dbba_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = dbba_pkg::S_IDLE;
        end
      end
      default: state_d = dbba_pkg::S_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready_o   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = ev_ptr_q;
    ram_wdata    = ram_rdata;
    rd_ptr_d     = rd_ptr_q;
    rd_base_d    = rd_base_q;
    ev_vld_d     = 1'b0;
    ev_ptr_d     = ev_ptr_q;
    ev_base_d    = ev_base_q;
    func_d       = func_q;
    limit_d      = limit_q;
    in_use_d     = in_use_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;

    case (state_q)
      dbba_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_ptr_q;
        ram_wdata = '0;
        rd_ptr_d  = (rd_ptr_q == AW'(MAP_WORDS - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      dbba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          func_d       = in_data_i.func;
          rd_ptr_d     = '0;
          rd_base_d    = '0;
          res_status_d = dbba_pkg::ST_RANGE;
          res_grant_d  = '0;
          if (in_data_i.func == dbba_pkg::FUNC_ALLOC) begin
            limit_d = managed;
          end else begin
            limit_d = BW'(free_idx) + BW'(1);
          end
        end
      end
      dbba_pkg::S_SCAN: begin
        // keep one word in flight ahead of the evaluation
        ev_vld_d  = issue;
        ev_ptr_d  = rd_ptr_q;
        ev_base_d = rd_base_q;
        if (issue) begin
          rd_ptr_d  = rd_ptr_q + AW'(1);
          rd_base_d = rd_base_q + BW'(WORD_BITS);
        end
        if (ev_vld_q) begin
          if (func_q == dbba_pkg::FUNC_ALLOC) begin
            if (alloc_hit) begin
              ram_we       = 1'b1;
              ram_wdata    = ram_rdata | sel_mask;
              in_use_d     = in_use_q + CW'(1);
              res_status_d = dbba_pkg::ST_OK;
              res_grant_d  = ds_q + 32'(ev_base_q) + 32'(alloc_off);
            end
          end else if (free_word) begin
            if (free_set) begin
              ram_we       = 1'b1;
              ram_wdata    = ram_rdata & ~sel_mask;
              in_use_d     = (in_use_q != '0) ? in_use_q - CW'(1) : in_use_q;
              res_status_d = dbba_pkg::ST_OK;
            end else begin
              res_status_d = dbba_pkg::ST_ALREADY;
            end
          end
        end else if (!issue) begin
          // whole managed range scanned without a clear bit
          res_status_d = dbba_pkg::ST_NOSPACE;
        end
      end
      dbba_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d              = 1'b1;
          out_data_d.status        = res_status_q;
          out_data_d.granted_block = res_grant_q;
          out_data_d.free_count    = free_cnt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dbba_pkg::S_CLEAR;
      ds_q        <= dbba_pkg::DATA_START_RST;
      bt_q        <= dbba_pkg::BLOCK_TOTAL_RST;
      in_use_q    <= '0;
      rd_ptr_q    <= '0;
      rd_base_q   <= '0;
      ev_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_base_q   <= rd_base_d;
      ev_vld_q    <= ev_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dbba_pkg::CFG_DATA_START:  ds_q <= cfg_wdata_i;
          dbba_pkg::CFG_BLOCK_TOTAL: bt_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    ev_ptr_q     <= ev_ptr_d;
    ev_base_q    <= ev_base_d;
    func_q       <= func_d;
    limit_q      <= limit_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    out_data_q   <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> design/dbba_checker.sv
// ---------------------------------------------------------------------------
// dbba_checker
// port-level checks of the bitmap allocator, bound to the top level
// ---------------------------------------------------------------------------
`include "data_block_bitmap_allocator_top_defines.svh"

module dbba_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input dbba_pkg::resp_t out_data_i
);

  // a response beat is held until taken
  `DBBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled response beat keeps its payload
  `DBBA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))

  // a response that is not a success carries no block number
  `DBBA_ASSERT_NOW(a_grant_zero, clk_i, rst_ni, out_valid_i && (out_data_i.status != dbba_pkg::ST_OK), out_data_i.granted_block == 32'd0)

  // no space means every managed block is in use
  `DBBA_ASSERT_NOW(a_nospace_full, clk_i, rst_ni, out_valid_i && (out_data_i.status == dbba_pkg::ST_NOSPACE), out_data_i.free_count == 13'd0)

endmodule

bind data_block_bitmap_allocator_top dbba_checker u_dbba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
